// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/atr_pkg.sv
package atr_pkg;

   // Sizing of the trunk sine lookup and of the angle fraction.
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int ANGLE_FRAC_BITS  = 6;
   localparam int LOG_DEPTH        = $clog2(SINE_TABLE_DEPTH);

   // Fixed field widths.
   localparam int ANGLE_W  = 15;
   localparam int TORQUE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int DELTA_W  = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Sine table: Q15 magnitudes, the last entry is exactly one (32768).
   localparam int SINE_FRAC   = 15;
   localparam int SINE_W      = SINE_FRAC + 1;
   localparam int SINE_ADDR_W = LOG_DEPTH + 1;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // Phase index = floor(delta * DEPTH / (90 << F)), done as a multiply by a
   // rounded-up reciprocal that is exact over the whole delta range.
   localparam int PHASE_DIV     = 90 << ANGLE_FRAC_BITS;
   localparam int PHASE_DIV_LOG = $clog2(PHASE_DIV);
   localparam int PHASE_SCALE   = DELTA_W + LOG_DEPTH + PHASE_DIV_LOG;
   localparam longint unsigned PHASE_RECIP =
      ((64'd1 << PHASE_SCALE) + 64'(PHASE_DIV) - 64'd1) / 64'(PHASE_DIV);
   localparam int RECIP_W     = DELTA_W + LOG_DEPTH + 1;
   localparam int PHASE_SHIFT = PHASE_SCALE - LOG_DEPTH;
   localparam int PHASE_MUL_W = DELTA_W + RECIP_W;
   localparam int PHASE_TOP_W = PHASE_SHIFT + LOG_DEPTH + 2;
   localparam int PHASE_PROD_W = (PHASE_MUL_W > PHASE_TOP_W) ? PHASE_MUL_W : PHASE_TOP_W;

   // Stiffness term = (stiffness * delta + half) >> F.
   localparam int STIFF_SUM_W = GAIN_W + DELTA_W + 1;
   localparam int STIFF_W     = STIFF_SUM_W - ANGLE_FRAC_BITS;
   localparam longint unsigned STIFF_HALF =
      (ANGLE_FRAC_BITS > 0) ? (64'd1 << ((ANGLE_FRAC_BITS > 0) ? ANGLE_FRAC_BITS - 1 : 0))
                            : 64'd0;

   // Gravity term = (gain * sine + half) >> 15, and the signed torque sum.
   localparam int GRAV_PROD_W = GAIN_W + SINE_W + 1;
   localparam int GRAV_W      = GRAV_PROD_W - SINE_FRAC;
   localparam int SUM_W       = ((GRAV_W > STIFF_W) ? GRAV_W : STIFF_W) + 2;

   // Activity and technique codes.
   localparam logic [1:0] ACT_STAND  = 2'd0;
   localparam logic [1:0] ACT_WALK   = 2'd1;
   localparam logic [1:0] ACT_EXIT   = 2'd2;
   localparam logic [1:0] ACT_BEND   = 2'd3;
   localparam logic [1:0] TECH_STOOP = 2'd0;
   localparam logic [1:0] TECH_SQUAT = 2'd1;
   localparam logic [1:0] TECH_SEMI  = 2'd2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRAVITY_GAIN    = 3'd0,
      CSR_STIFFNESS       = 3'd1,
      CSR_TORQUE_LIMIT    = 3'd2,
      CSR_TRUNK_REF       = 3'd3,
      CSR_THIGH_LEFT_REF  = 3'd4,
      CSR_THIGH_RIGHT_REF = 3'd5
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [GAIN_W-1:0]   GRAVITY_GAIN_RESET = 16'd2960;
   localparam logic [GAIN_W-1:0]   STIFFNESS_RESET    = 16'd51;
   localparam logic [TORQUE_W-1:0] TORQUE_LIMIT_RESET = 16'd5120;

   typedef struct packed {
      logic [GAIN_W-1:0]          gravity_gain;
      logic [GAIN_W-1:0]          stiffness;
      logic [TORQUE_W-1:0]        torque_limit;
      logic signed [ANGLE_W-1:0]  trunk_ref_angle;
      logic signed [ANGLE_W-1:0]  thigh_left_ref;
      logic signed [ANGLE_W-1:0]  thigh_right_ref;
   } csr_type;

   // What the first stage hands to the torque stage.
   typedef struct packed {
      logic                strategy_on;
      logic [1:0]          activity;
      logic [1:0]          technique;
      logic [SINE_W-1:0]   sine_mag;
      logic                sine_neg;
      logic [STIFF_W-1:0]  stiff_left;
      logic [STIFF_W-1:0]  stiff_right;
   } stage_type;

   typedef logic [SINE_W-1:0] sine_rom_type [SINE_TABLE_DEPTH+1];

   // Truncated quotient of two non-negative constants, by shift and subtract.
   function automatic longint const_quotient(longint num, longint den);
      longint rem;
      longint quo;
      rem = 0;
      quo = 0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
         quo = quo <<< 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'sd1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave sine, built at elaboration by a Taylor series in Q30.
   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      longint x;
      longint x2;
      longint term;
      longint sum;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >>> 30;
         term = x;
         sum  = x;
         for (int k = 1; k <= 12; k++) begin
            term = const_quotient((term * x2) >>> 30, longint'((2 * k) * (2 * k + 1)));
            if (k % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rom[i] = SINE_W'((sum + 64'sd16384) >>> 15);
      end
      rom[SINE_TABLE_DEPTH] = SINE_W'(32768);
      rom[0] = '0;
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

endpackage

// File: sv/atr_if.sv
interface atr_req_if;
   import atr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       strategy_on;
   logic [1:0]                 activity;
   logic [1:0]                 technique;
   logic signed [ANGLE_W-1:0]  trunk_angle;
   logic signed [ANGLE_W-1:0]  thigh_left_angle;
   logic signed [ANGLE_W-1:0]  thigh_right_angle;

   modport source (output valid, strategy_on, activity, technique, trunk_angle,
                   thigh_left_angle, thigh_right_angle, input ready);
   modport sink (input valid, strategy_on, activity, technique, trunk_angle,
                 thigh_left_angle, thigh_right_angle, output ready);
endinterface

interface atr_rsp_if;
   import atr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [TORQUE_W-1:0]  torque_left;
   logic [TORQUE_W-1:0]  torque_right;
   logic [TORQUE_W-1:0]  prev_torque_left;
   logic [TORQUE_W-1:0]  prev_torque_right;
   logic                 motor_enable;
   logic                 reset_controller;

   modport source (output valid, torque_left, torque_right, prev_torque_left,
                   prev_torque_right, motor_enable, reset_controller, input ready);
   modport sink (input valid, torque_left, torque_right, prev_torque_left,
                 prev_torque_right, motor_enable, reset_controller, output ready);
endinterface

// File: sv/atr_csr.sv
module atr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [atr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [atr_pkg::CSR_DATA_W-1:0]      csr_data,
   output atr_pkg::csr_type                    cfg
);
   import atr_pkg::*;

   csr_type cfg_ff;
   csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRAVITY_GAIN:    cfg_in.gravity_gain    = csr_data[GAIN_W-1:0];
            CSR_STIFFNESS:       cfg_in.stiffness       = csr_data[GAIN_W-1:0];
            CSR_TORQUE_LIMIT:    cfg_in.torque_limit    = csr_data[TORQUE_W-1:0];
            CSR_TRUNK_REF:       cfg_in.trunk_ref_angle = signed'(csr_data[ANGLE_W-1:0]);
            CSR_THIGH_LEFT_REF:  cfg_in.thigh_left_ref  = signed'(csr_data[ANGLE_W-1:0]);
            CSR_THIGH_RIGHT_REF: cfg_in.thigh_right_ref = signed'(csr_data[ANGLE_W-1:0]);
            default: begin
               // Writes to unused indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity_gain    <= GRAVITY_GAIN_RESET;
         cfg_ff.stiffness       <= STIFFNESS_RESET;
         cfg_ff.torque_limit    <= TORQUE_LIMIT_RESET;
         cfg_ff.trunk_ref_angle <= '0;
         cfg_ff.thigh_left_ref  <= '0;
         cfg_ff.thigh_right_ref <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/atr_front.sv
module atr_front (
   input  logic                 clock,
   input  logic                 reset,
   atr_req_if.sink              req,
   input  atr_pkg::csr_type     cfg,
   input  logic                 take,
   output logic                 stage_valid,
   output atr_pkg::stage_type   stage
);
   import atr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   stage_type  stage_ff;
   stage_type  stage_in;
   logic       accept;

   logic [DELTA_W-1:0]       trunk_delta;
   logic [DELTA_W-1:0]       left_delta;
   logic [DELTA_W-1:0]       right_delta;
   logic [PHASE_PROD_W-1:0]  phase_prod;
   logic [LOG_DEPTH-1:0]     phase_pos;
   logic [1:0]               phase_quad;
   logic [SINE_ADDR_W-1:0]   sine_addr;
   logic [STIFF_SUM_W-1:0]   left_prod;
   logic [STIFF_SUM_W-1:0]   right_prod;

   // Angle above its reference, floored at zero.
   function automatic logic [DELTA_W-1:0] delta_of(logic signed [ANGLE_W-1:0] angle,
                                                   logic signed [ANGLE_W-1:0] ref_angle);
      logic signed [ANGLE_W:0] diff;
      diff = {angle[ANGLE_W-1], angle} - {ref_angle[ANGLE_W-1], ref_angle};
      if (diff < 0) begin
         return '0;
      end
      return diff[DELTA_W-1:0];
   endfunction

   assign accept    = req.valid && req.ready;
   assign req.ready = !valid_ff || take;

   always_comb begin
      trunk_delta = delta_of(req.trunk_angle, cfg.trunk_ref_angle);
      left_delta  = delta_of(req.thigh_left_angle, cfg.thigh_left_ref);
      right_delta = delta_of(req.thigh_right_angle, cfg.thigh_right_ref);

      // Phase index of the trunk delta, then quadrant folding of the table.
      phase_prod = PHASE_PROD_W'(trunk_delta) * PHASE_PROD_W'(PHASE_RECIP);
      phase_pos  = phase_prod[PHASE_SHIFT +: LOG_DEPTH];
      phase_quad = phase_prod[PHASE_SHIFT + LOG_DEPTH +: 2];
      if (phase_quad[0]) begin
         sine_addr = SINE_ADDR_W'(SINE_TABLE_DEPTH) - SINE_ADDR_W'(phase_pos);
      end else begin
         sine_addr = SINE_ADDR_W'(phase_pos);
      end

      left_prod  = STIFF_SUM_W'(cfg.stiffness) * STIFF_SUM_W'(left_delta);
      right_prod = STIFF_SUM_W'(cfg.stiffness) * STIFF_SUM_W'(right_delta);

      stage_in.strategy_on = req.strategy_on;
      stage_in.activity    = req.activity;
      stage_in.technique   = req.technique;
      stage_in.sine_mag    = SINE_ROM[sine_addr];
      stage_in.sine_neg    = phase_quad[1];
      stage_in.stiff_left  =
         STIFF_W'((left_prod + STIFF_SUM_W'(STIFF_HALF)) >> ANGLE_FRAC_BITS);
      stage_in.stiff_right =
         STIFF_W'((right_prod + STIFF_SUM_W'(STIFF_HALF)) >> ANGLE_FRAC_BITS);
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

// File: sv/atr_torque.sv
`include "assert_macros.svh"

module atr_torque (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 stage_valid,
   input  atr_pkg::stage_type   stage,
   input  atr_pkg::csr_type     cfg,
   output logic                 take,
   atr_rsp_if.source            rsp
);
   import atr_pkg::*;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [TORQUE_W-1:0]  out_left_ff;
   logic [TORQUE_W-1:0]  out_right_ff;
   logic [TORQUE_W-1:0]  out_prev_left_ff;
   logic [TORQUE_W-1:0]  out_prev_right_ff;
   logic                 out_enable_ff;
   logic                 out_rst_ff;

   logic [TORQUE_W-1:0]  last_left_ff;
   logic [TORQUE_W-1:0]  last_right_ff;
   logic                 enable_ff;

   logic [GRAV_PROD_W-1:0]   grav_prod;
   logic [GRAV_W-1:0]        grav_mag;
   logic signed [SUM_W-1:0]  grav_s;
   logic signed [SUM_W-1:0]  stiff_left_s;
   logic signed [SUM_W-1:0]  stiff_right_s;
   logic signed [SUM_W-1:0]  total_left;
   logic signed [SUM_W-1:0]  total_right;
   logic [TORQUE_W-1:0]      left_in;
   logic [TORQUE_W-1:0]      right_in;
   logic                     enable_in;
   logic                     rst_in;

   function automatic logic [TORQUE_W-1:0] clamp_torque(logic signed [SUM_W-1:0] t,
                                                        logic [TORQUE_W-1:0] limit);
      if (t >= signed'(SUM_W'(limit))) begin
         return limit;
      end else if (t < 0) begin
         return '0;
      end
      return TORQUE_W'(t);
   endfunction

   assign take = stage_valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      grav_prod = GRAV_PROD_W'(cfg.gravity_gain) * GRAV_PROD_W'(stage.sine_mag);
      grav_mag  = GRAV_W'((grav_prod + GRAV_PROD_W'(1 << (SINE_FRAC - 1))) >> SINE_FRAC);
      grav_s    = signed'(SUM_W'(grav_mag));
      if (stage.sine_neg) begin
         grav_s = -grav_s;
      end
      if (stage.technique == TECH_SQUAT) begin
         grav_s = '0;
      end

      stiff_left_s  = signed'(SUM_W'(stage.stiff_left));
      stiff_right_s = signed'(SUM_W'(stage.stiff_right));
      if (stage.technique == TECH_STOOP) begin
         stiff_left_s  = '0;
         stiff_right_s = '0;
      end

      total_left  = grav_s + stiff_left_s;
      total_right = grav_s + stiff_right_s;
      enable_in   = enable_ff;
      rst_in      = 1'b0;
      if (!stage.strategy_on) begin
         total_left  = signed'(SUM_W'(last_left_ff));
         total_right = signed'(SUM_W'(last_right_ff));
      end else if (stage.activity != ACT_BEND) begin
         total_left  = '0;
         total_right = '0;
         enable_in   = (stage.activity == ACT_WALK);
         rst_in      = (stage.activity == ACT_EXIT);
      end else begin
         enable_in = 1'b1;
      end

      left_in  = clamp_torque(total_left, cfg.torque_limit);
      right_in = clamp_torque(total_right, cfg.torque_limit);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         enable_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            last_left_ff  <= left_in;
            last_right_ff <= right_in;
            enable_ff     <= enable_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_left_ff       <= left_in;
         out_right_ff      <= right_in;
         out_prev_left_ff  <= last_left_ff;
         out_prev_right_ff <= last_right_ff;
         out_enable_ff     <= enable_in;
         out_rst_ff        <= rst_in;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.torque_left       = out_left_ff;
   assign rsp.torque_right      = out_right_ff;
   assign rsp.prev_torque_left  = out_prev_left_ff;
   assign rsp.prev_torque_right = out_prev_right_ff;
   assign rsp.motor_enable      = out_enable_ff;
   assign rsp.reset_controller  = out_rst_ff;

   `ASSERT_IMPLIES(a_left_within_limit, clock, reset, out_valid_ff, out_left_ff <= cfg.torque_limit)
   `ASSERT_IMPLIES(a_exit_is_quiet, clock, reset, out_valid_ff && out_rst_ff, !out_enable_ff && out_left_ff == '0 && out_right_ff == '0)
   `ASSERT_NEXT(a_state_tracks_result, clock, reset, take, last_left_ff == out_left_ff && last_right_ff == out_right_ff && enable_ff == out_enable_ff)
   `ASSERT_NEXT(a_prev_is_old_state, clock, reset, take, out_prev_left_ff == $past(last_left_ff) && out_prev_right_ff == $past(last_right_ff))

endmodule

// File: sv/assist_torque_reference.sv
// Assist torque reference: one beat on req_chan is one control tick and yields
// exactly one beat on rsp_chan, in order. A tick is taken in every cycle
// unless both stage registers are full and rsp_chan stalls. The front stage
// logic (angle deltas, the reciprocal multiply that finds the sine phase, the
// quarter-wave table read and the two thigh stiffness products) works on the
// request while it is offered and is registered by the accepting edge; the
// torque stage (the gravity gain multiply, the sum and the clamp to the torque
// limit, and the update of the held torques and enable) works on the stored
// tick and fills the result register. A result waiting on rsp_chan does not
// stop the next tick entering an empty front stage. The user must write
// configuration registers through the csr_ port only while the block is idle;
// the block does not enforce this. Reset values are a gravity gain of 2960, a
// stiffness of 51 and a torque limit of 5120 (all Q8.8), with all three
// reference angles at zero. Held torques and the motor enable reset to zero.

module assist_torque_reference (
   input  logic                              clock,
   input  logic                              reset,
   atr_req_if.sink                           req_chan,
   atr_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [atr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [atr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import atr_pkg::*;

   // Live register set, shared by both stages. The user must change it only
   // while idle (not enforced by the block), so a tick sees the same values.
   csr_type    cfg;
   // Front stage to torque stage: a valid flag, the stage contents and the
   // take strobe that tells the front stage its contents have moved on.
   stage_type  stage;
   logic       stage_valid;
   logic       take;

   atr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Front stage: the input register, fed by the delta and phase logic.
   atr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .cfg         (cfg),
      .take        (take),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   // Torque stage: the result register and the state carried between
   // ticks. With the strategy off the held torques are re-clamped to the
   // present limit and the enable is kept.
   atr_torque u_torque (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .cfg         (cfg),
      .take        (take),
      .rsp         (rsp_chan)
   );

endmodule
